// File: rtl/pivot_partitioned_list_macros.svh
// Assertion macros shared by the RTL files.
`ifndef PIVOT_PARTITIONED_LIST_MACROS_SVH
`define PIVOT_PARTITIONED_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define PPL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PPL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPL_ASSERT_ALWAYS(label, expr, msg)
`define PPL_ASSERT_IMPLY(label, ante, cons, msg)
`define PPL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/ppl_pkg.sv
`default_nettype none
package ppl_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_DEL_PREV = 3'd1;
    localparam logic [2:0] CMD_DEL_NEXT = 3'd2;
    localparam logic [2:0] CMD_COUNT    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_CLEAR    = 3'd5;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_PIVOT = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_ADD_LEFT,
        OP_ADD_RIGHT,
        OP_REJECT,
        OP_DEL_LEFT,
        OP_DEL_RIGHT,
        OP_COUNT,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [6:0]  position;
        logic        pivot_eq;
    } work_t;

endpackage
`default_nettype wire

// File: rtl/ppl_ram.sv
`default_nettype none
module ppl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/ppl_front.sv
`default_nettype none
module ppl_front
    import ppl_pkg::*;
#(
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] elem_value,
    input  wire logic [6:0]  position,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] pivot_value,
    input  wire logic        q_full,
    output logic             busy,
    output logic             push,
    output work_t            push_word,
    output logic [31:0]      pivot_raw
);

    logic [31:0]                   pivot_reg;
    logic [31:0]                   pivot_next;
    logic signed [63:0]            elem_x;
    logic signed [63:0]            pivot_x;
    logic signed [ELEM_WIDTH-1:0]  elem_e;
    logic signed [ELEM_WIDTH-1:0]  pivot_e;
    logic                          is_eq;
    logic                          is_less;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign push      = start && !q_full;
    assign pivot_raw = pivot_reg;

    always_comb
    begin
        pivot_next = pivot_reg;
        if (cfg_valid && cfg_ready)
        begin
            pivot_next = pivot_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg <= '0;
        end
        else
        begin
            pivot_reg <= pivot_next;
        end
    end

    assign elem_x  = 64'(signed'(elem_value));
    assign pivot_x = 64'(signed'(pivot_reg));
    assign elem_e  = elem_x[ELEM_WIDTH-1:0];
    assign pivot_e = pivot_x[ELEM_WIDTH-1:0];
    assign is_eq   = (elem_e == pivot_e);
    assign is_less = (elem_e < pivot_e);

    always_comb
    begin
        push_word.value    = elem_value;
        push_word.position = position;
        push_word.pivot_eq = is_eq;
        case (cmd)
            CMD_ADD:
            begin
                if (is_eq)
                begin
                    push_word.op = OP_REJECT;
                end
                else if (is_less)
                begin
                    push_word.op = OP_ADD_LEFT;
                end
                else
                begin
                    push_word.op = OP_ADD_RIGHT;
                end
            end
            CMD_DEL_PREV: push_word.op = OP_DEL_LEFT;
            CMD_DEL_NEXT: push_word.op = OP_DEL_RIGHT;
            CMD_COUNT:    push_word.op = OP_COUNT;
            CMD_READ:     push_word.op = OP_READ;
            CMD_CLEAR:    push_word.op = OP_CLEAR;
            default:      push_word.op = OP_NOP;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/ppl_queue.sv
`default_nettype none
`include "pivot_partitioned_list_macros.svh"
module ppl_queue
    import ppl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  work_t      push_word,
    output logic       full,
    input  wire logic  pop,
    output work_t      pop_word,
    output logic       empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    `PPL_ASSERT_ALWAYS(a_q_no_overflow, !(push && full), "queue pushed while full")
    `PPL_ASSERT_ALWAYS(a_q_no_underflow, !(pop && empty), "queue popped while empty")
    `PPL_ASSERT_ALWAYS(a_q_count_range, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count too large")

endmodule
`default_nettype wire

// File: rtl/ppl_back.sv
`default_nettype none
`include "pivot_partitioned_list_macros.svh"
module ppl_back
    import ppl_pkg::*;
#(
    parameter int SIDE_DEPTH = 32,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  work_t            q_word,
    output logic             pop,
    input  wire logic [31:0] pivot_raw,
    output logic             done,
    output logic [2:0]       status,
    output logic [6:0]       list_length,
    output logic [6:0]       match_count,
    output logic [31:0]      read_value
);

    localparam int PW = $clog2(SIDE_DEPTH);
    localparam int FW = $clog2(SIDE_DEPTH + 1);
    localparam int CW = ((FW > 7) ? FW : 7) + 2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [PW-1:0]          lwp_reg, lwp_next, lrp_reg, lrp_next;
    logic [PW-1:0]          rwp_reg, rwp_next, rrp_reg, rrp_next;
    logic [FW-1:0]          lfill_reg, lfill_next, rfill_reg, rfill_next;
    logic [FW-1:0]          idx_reg, idx_next;
    logic [PW-1:0]          la_reg, la_next, ra_reg, ra_next;
    logic                   lv_reg, lv_next, rv_reg, rv_next;
    logic [6:0]             match_reg, match_next;
    logic [ELEM_WIDTH-1:0]  key_reg, key_next;
    logic                   side_reg, side_next;
    logic                   done_reg, done_next;
    logic [2:0]             status_reg, status_next;
    logic [6:0]             len_reg, len_next;
    logic [6:0]             mc_reg, mc_next;
    logic [31:0]            rdv_reg, rdv_next;

    logic signed [63:0]           word_x;
    logic signed [63:0]           pivot_x;
    logic signed [ELEM_WIDTH-1:0] word_e;
    logic signed [ELEM_WIDTH-1:0] pivot_e;
    logic signed [63:0]           pivot_back_x;
    logic signed [ELEM_WIDTH-1:0] ram_sel;
    logic signed [63:0]           ram_sel_x;

    logic                   we_l, we_r;
    logic [PW-1:0]          raddr_l, raddr_r;
    logic [ELEM_WIDTH-1:0]  rdata_l, rdata_r;

    logic [CW-1:0]          pos_c, lf_c, rf_c, len_c, lidx_c, ridx_c, len_out_c;
    logic                   issue_l, issue_r;
    logic [6:0]             match_sum;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        bump = (p == PW'(SIDE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign word_x       = 64'(signed'(q_word.value));
    assign word_e       = word_x[ELEM_WIDTH-1:0];
    assign pivot_x      = 64'(signed'(pivot_raw));
    assign pivot_e      = pivot_x[ELEM_WIDTH-1:0];
    assign pivot_back_x = 64'(pivot_e);
    assign ram_sel      = side_reg ? rdata_r : rdata_l;
    assign ram_sel_x    = 64'(ram_sel);

    assign pos_c = CW'(q_word.position);
    assign lf_c  = CW'(lfill_reg);
    assign rf_c  = CW'(rfill_reg);
    assign len_c = lf_c + rf_c + CW'(1);

    always_comb
    begin
        lidx_c = CW'(lwp_reg) - (pos_c + CW'(1));
        if (lidx_c[CW-1])
        begin
            lidx_c = lidx_c + CW'(SIDE_DEPTH);
        end
        ridx_c = CW'(rrp_reg) + pos_c - lf_c - CW'(1);
        if (ridx_c >= CW'(SIDE_DEPTH))
        begin
            ridx_c = ridx_c - CW'(SIDE_DEPTH);
        end
    end

    assign pop     = (state_reg == S_IDLE) && !q_empty;
    assign issue_l = (idx_reg < lfill_reg);
    assign issue_r = (idx_reg < rfill_reg);
    assign raddr_l = (state_reg == S_SCAN) ? la_reg : lidx_c[PW-1:0];
    assign raddr_r = (state_reg == S_SCAN) ? ra_reg : ridx_c[PW-1:0];
    assign we_l    = pop && (q_word.op == OP_ADD_LEFT) && (lfill_reg != FW'(SIDE_DEPTH));
    assign we_r    = pop && (q_word.op == OP_ADD_RIGHT) && (rfill_reg != FW'(SIDE_DEPTH));

    assign match_sum = match_reg
                     + 7'((lv_reg && (rdata_l == key_reg)) ? 1 : 0)
                     + 7'((rv_reg && (rdata_r == key_reg)) ? 1 : 0);

    ppl_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (we_l),
        .waddr (lwp_reg),
        .wdata (word_e),
        .raddr (raddr_l),
        .rdata (rdata_l)
    );

    ppl_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (SIDE_DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (we_r),
        .waddr (rwp_reg),
        .wdata (word_e),
        .raddr (raddr_r),
        .rdata (rdata_r)
    );

    always_comb
    begin
        state_next  = state_reg;
        lwp_next    = lwp_reg;
        lrp_next    = lrp_reg;
        rwp_next    = rwp_reg;
        rrp_next    = rrp_reg;
        lfill_next  = lfill_reg;
        rfill_next  = rfill_reg;
        idx_next    = idx_reg;
        la_next     = la_reg;
        ra_next     = ra_reg;
        lv_next     = 1'b0;
        rv_next     = 1'b0;
        match_next  = match_reg;
        key_next    = key_reg;
        side_next   = side_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        mc_next     = '0;
        rdv_next    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (q_word.op)
                        OP_ADD_LEFT:
                        begin
                            done_next = 1'b1;
                            if (lfill_reg == FW'(SIDE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                lwp_next   = bump(lwp_reg);
                                lfill_next = lfill_reg + FW'(1);
                            end
                        end
                        OP_ADD_RIGHT:
                        begin
                            done_next = 1'b1;
                            if (rfill_reg == FW'(SIDE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                rwp_next   = bump(rwp_reg);
                                rfill_next = rfill_reg + FW'(1);
                            end
                        end
                        OP_REJECT:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_PIVOT;
                        end
                        OP_DEL_LEFT:
                        begin
                            done_next = 1'b1;
                            if (lfill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                lrp_next   = bump(lrp_reg);
                                lfill_next = lfill_reg - FW'(1);
                            end
                        end
                        OP_DEL_RIGHT:
                        begin
                            done_next = 1'b1;
                            if (rfill_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rrp_next   = bump(rrp_reg);
                                rfill_next = rfill_reg - FW'(1);
                            end
                        end
                        OP_COUNT:
                        begin
                            state_next = S_SCAN;
                            idx_next   = '0;
                            la_next    = lrp_reg;
                            ra_next    = rrp_reg;
                            key_next   = word_e;
                            match_next = q_word.pivot_eq ? 7'd1 : 7'd0;
                        end
                        OP_READ:
                        begin
                            if (pos_c >= len_c)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                            end
                            else if (pos_c < lf_c)
                            begin
                                state_next = S_READ;
                                side_next  = 1'b0;
                            end
                            else if (pos_c == lf_c)
                            begin
                                done_next = 1'b1;
                                rdv_next  = pivot_back_x[31:0];
                            end
                            else
                            begin
                                state_next = S_READ;
                                side_next  = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            lwp_next   = '0;
                            lrp_next   = '0;
                            rwp_next   = '0;
                            rrp_next   = '0;
                            lfill_next = '0;
                            rfill_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                match_next = match_sum;
                if (issue_l || issue_r)
                begin
                    lv_next  = issue_l;
                    rv_next  = issue_r;
                    la_next  = bump(la_reg);
                    ra_next  = bump(ra_reg);
                    idx_next = idx_reg + FW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    mc_next    = match_sum;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rdv_next   = ram_sel_x[31:0];
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign len_out_c = CW'(lfill_next) + CW'(rfill_next) + CW'(1);
    assign len_next  = len_out_c[6:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lwp_reg   <= '0;
            lrp_reg   <= '0;
            rwp_reg   <= '0;
            rrp_reg   <= '0;
            lfill_reg <= '0;
            rfill_reg <= '0;
            lv_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lwp_reg   <= lwp_next;
            lrp_reg   <= lrp_next;
            rwp_reg   <= rwp_next;
            rrp_reg   <= rrp_next;
            lfill_reg <= lfill_next;
            rfill_reg <= rfill_next;
            lv_reg    <= lv_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        la_reg     <= la_next;
        ra_reg     <= ra_next;
        match_reg  <= match_next;
        key_reg    <= key_next;
        side_reg   <= side_next;
        status_reg <= status_next;
        len_reg    <= len_next;
        mc_reg     <= mc_next;
        rdv_reg    <= rdv_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign list_length = len_reg;
    assign match_count = mc_reg;
    assign read_value  = rdv_reg;

    `PPL_ASSERT_ALWAYS(a_fill_bound, (lfill_reg <= FW'(SIDE_DEPTH)) && (rfill_reg <= FW'(SIDE_DEPTH)), "side fill beyond depth")
    `PPL_ASSERT_NEXT(a_scan_exit, state_reg == S_SCAN, (state_reg == S_SCAN) || done_reg, "scan left without a result")
    `PPL_ASSERT_NEXT(a_read_one, state_reg == S_READ, (state_reg == S_IDLE) && done_reg, "read did not finish in one cycle")
    `PPL_ASSERT_IMPLY(a_pend_in_scan, lv_reg || rv_reg, (state_reg == S_SCAN) || done_reg, "scan compare pending outside scan")

endmodule
`default_nettype wire

// File: rtl/pivot_partitioned_list.sv
// Channel   Direction  Handshake             Word
// command   in         start & !busy         cmd, elem_value, position
// result    out        done (one cycle)      status, list_length, match_count, read_value
// config    in         cfg_valid & cfg_ready pivot_value
//
// Add, delete, clear, unused codes, read of the pivot or out of range: the result is
// registered straight from the queued command. Read of a side element: through S_READ,
// for the registered side RAM read. Count: a scan over the two side RAMs, one RAM word
// per side per cycle, until max(left fill, right fill) words are covered.
// busy rises when the two-word command queue is full; the result side has no stall.
// rst_n clears pointers, fills and the pivot; no clearing pass, RAM contents stay.
`default_nettype none
module pivot_partitioned_list
    import ppl_pkg::*;
#(
    parameter int SIDE_DEPTH = 32,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] elem_value,
    input  wire logic [6:0]  position,
    output logic             done,
    output logic [2:0]       status,
    output logic [6:0]       list_length,
    output logic [6:0]       match_count,
    output logic [31:0]      read_value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] pivot_value
);

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    work_t       push_word;
    work_t       pop_word;
    logic [31:0] pivot_raw;

    ppl_front #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .elem_value  (elem_value),
        .position    (position),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .pivot_value (pivot_value),
        .q_full      (q_full),
        .busy        (busy),
        .push        (push),
        .push_word   (push_word),
        .pivot_raw   (pivot_raw)
    );

    ppl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .pop       (pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    ppl_back #(
        .SIDE_DEPTH (SIDE_DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_word      (pop_word),
        .pop         (pop),
        .pivot_raw   (pivot_raw),
        .done        (done),
        .status      (status),
        .list_length (list_length),
        .match_count (match_count),
        .read_value  (read_value)
    );

endmodule
`default_nettype wire
